// ----- sv/rps_pkg.sv -----
// ============================================================================
// rps_pkg - shared types and constants of the relay precharge sequencer
// Holds the item and result transaction types, sequencer state types,
// configuration register set and register indexes.
// ============================================================================
package rps_pkg;

    // System mode codes carried by an item.
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_CHARGE = 3'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_VOLTAGE_CHECK = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRECHARGE_DELAY   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRECHARGE_TIMEOUT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARGE_MODE_DELAY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RATIO_THRESHOLD   = 3'd4;

    // Register reset values (233/256 is roughly 0.91).
    localparam logic        RST_USE_VOLTAGE_CHECK = 1'b1;
    localparam logic [15:0] RST_PRECHARGE_DELAY   = 16'd1000;
    localparam logic [15:0] RST_PRECHARGE_TIMEOUT = 16'd3000;
    localparam logic [15:0] RST_CHARGE_MODE_DELAY = 16'd2000;
    localparam logic [8:0]  RST_RATIO_THRESHOLD   = 9'd233;

    typedef enum logic [1:0] {
        PH_OPENED  = 2'd0,
        PH_CLOSING = 2'd1,
        PH_CLOSED  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_STANDBY   = 3'd0,
        ST_ABORTED   = 3'd1,
        ST_PREPARE   = 3'd2,
        ST_PRECHARGE = 3'd3,
        ST_WAIT      = 3'd4,
        ST_AIRP      = 3'd5,
        ST_FINISH    = 3'd6
    } step_t;

    typedef struct packed {
        logic precharge;
        logic air_pos;
        logic air_neg;
        logic discharge;
    } relay_drive_t;

    typedef struct packed {
        phase_t       phase;
        step_t        step;
        logic [31:0]  time_reference;
        relay_drive_t drive;
    } seq_state_t;

    typedef struct packed {
        logic        use_voltage_check;
        logic [15:0] precharge_delay;
        logic [15:0] precharge_timeout;
        logic [15:0] charge_mode_delay;
        logic [8:0]  ratio_threshold;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        open_request;
        logic        close_request;
        logic        charge_finished;
        logic [31:0] time_ms;
        logic [15:0] drive_voltage;
        logic [15:0] pack_voltage;
    } item_t;

    typedef struct packed {
        logic       discharge_closed;
        logic       air_neg_closed;
        logic       air_pos_closed;
        logic       precharge_closed;
        logic [1:0] relay_status;
        logic [2:0] sequence_step;
        logic       timed_out;
    } result_t;

endpackage

// ----- sv/relay_precharge_sequencer_core.sv -----
// ============================================================================
// relay_precharge_sequencer_core - battery contactor precharge sequencer
// Takes a tick per cycle unless the result stalls, and drives the discharge, AIR-,
// AIR+ and precharge relays through the closing sequence, with abort on timeout.
// ============================================================================
//
//  Channel   Signals                                  Direction
//  --------  ---------------------------------------  ---------
//  item      item_valid, item_stall, item             in
//  result    result_valid, result_stall, result       out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// A tick is registered in the input register on acceptance, its next state is
// computed from that register and written into the result register, which
// offers the result, and while the result is not stalled one tick is taken
// every cycle. The sequencer state updates when the tick moves into the
// result register. Reset puts the relays open with the discharge relay
// closed and loads the register defaults. A stalled result holds the
// pipeline; item_stall rises only when both stages are full and the result
// is stalled.
//
module relay_precharge_sequencer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  rps_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output rps_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    rps_pkg::cfg_t       cfg_reg;
    rps_pkg::seq_state_t state_reg;
    rps_pkg::seq_state_t state_next;
    rps_pkg::item_t      item_reg;
    logic                item_valid_reg;
    rps_pkg::result_t    result_reg;
    rps_pkg::result_t    result_next;
    logic                result_valid_reg;
    logic                timed_out;
    logic                advance;
    logic                take_item;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_voltage_check <= rps_pkg::RST_USE_VOLTAGE_CHECK;
            cfg_reg.precharge_delay   <= rps_pkg::RST_PRECHARGE_DELAY;
            cfg_reg.precharge_timeout <= rps_pkg::RST_PRECHARGE_TIMEOUT;
            cfg_reg.charge_mode_delay <= rps_pkg::RST_CHARGE_MODE_DELAY;
            cfg_reg.ratio_threshold   <= rps_pkg::RST_RATIO_THRESHOLD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rps_pkg::REG_USE_VOLTAGE_CHECK: cfg_reg.use_voltage_check <= cfg_data[0];
                rps_pkg::REG_PRECHARGE_DELAY:   cfg_reg.precharge_delay   <= cfg_data;
                rps_pkg::REG_PRECHARGE_TIMEOUT: cfg_reg.precharge_timeout <= cfg_data;
                rps_pkg::REG_CHARGE_MODE_DELAY: cfg_reg.charge_mode_delay <= cfg_data;
                rps_pkg::REG_RATIO_THRESHOLD:   cfg_reg.ratio_threshold   <= cfg_data[8:0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Pipeline flow control.
    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = item_valid_reg && !advance;
    assign take_item  = item_valid && !item_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!item_stall)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
            item_reg <= item;
    end

    rps_step u_step
    (
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .item      (item_reg),
        .nxt       (state_next),
        .timed_out (timed_out)
    );

    // Sequencer state moves on with each transaction that leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= rps_pkg::PH_OPENED;
            state_reg.step           <= rps_pkg::ST_STANDBY;
            state_reg.time_reference <= 32'd0;
            state_reg.drive          <= '{precharge: 1'b0, air_pos: 1'b0,
                                          air_neg: 1'b0, discharge: 1'b1};
        end
        else if (item_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result formatting.
    always_comb
    begin
        result_next.discharge_closed = state_next.drive.discharge;
        result_next.air_neg_closed   = state_next.drive.air_neg;
        result_next.air_pos_closed   = state_next.drive.air_pos;
        result_next.precharge_closed = state_next.drive.precharge;
        result_next.relay_status     = state_next.phase;
        result_next.sequence_step    = state_next.step;
        result_next.timed_out        = timed_out;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- sv/rps_step.sv -----
// ============================================================================
// rps_step - next-state logic of the contactor closing sequence
// Works out, for one tick, whether to open or close, advances the closing
// sequence or opens the relays, and runs the precharge end and timeout checks.
// ============================================================================
module rps_step
(
    input  rps_pkg::seq_state_t cur,
    input  rps_pkg::cfg_t       cfg,
    input  rps_pkg::item_t      item,
    output rps_pkg::seq_state_t nxt,
    output logic                timed_out
);

    logic        open_sel;
    logic        chg_active;
    logic [31:0] elapsed;
    logic [24:0] ratio_rhs;
    logic [24:0] ratio_lhs;
    logic        ratio_ok;
    logic        pre_done;
    logic        pre_timeout;

    // Open wins over close; without requests the mode decides.
    always_comb
    begin
        chg_active = (item.mode == rps_pkg::MODE_CHARGE);
        if (item.open_request)
            open_sel = 1'b1;
        else if (item.close_request)
            open_sel = 1'b0;
        else if (item.mode == rps_pkg::MODE_NORMAL)
            open_sel = 1'b0;
        else if (chg_active)
            open_sel = item.charge_finished;
        else
            open_sel = 1'b1;
    end

    // Precharge checks: exact voltage ratio and wrapping elapsed time.
    assign elapsed   = item.time_ms - cur.time_reference;
    assign ratio_rhs = {16'd0, cfg.ratio_threshold} * {9'd0, item.pack_voltage};
    assign ratio_lhs = {1'b0, item.drive_voltage, 8'd0};
    assign ratio_ok  = (ratio_lhs > ratio_rhs);

    always_comb
    begin
        if (chg_active)
        begin
            pre_done    = (elapsed > {16'd0, cfg.charge_mode_delay});
            pre_timeout = 1'b0;
        end
        else
        begin
            pre_done    = cfg.use_voltage_check ? ratio_ok
                                                : (elapsed > {16'd0, cfg.precharge_delay});
            pre_timeout = (elapsed > {16'd0, cfg.precharge_timeout});
        end
    end

    // Sequence update for this tick.
    always_comb
    begin
        nxt       = cur;
        timed_out = 1'b0;
        if (open_sel)
        begin
            case (cur.phase)
                rps_pkg::PH_CLOSING:
                begin
                    nxt.step  = rps_pkg::ST_ABORTED;
                    nxt.drive = '{precharge: 1'b0, air_pos: 1'b0,
                                  air_neg: 1'b0, discharge: 1'b1};
                    nxt.phase = rps_pkg::PH_OPENED;
                end
                rps_pkg::PH_CLOSED:
                begin
                    nxt.drive = '{precharge: 1'b0, air_pos: 1'b0,
                                  air_neg: 1'b0, discharge: 1'b1};
                    nxt.phase = rps_pkg::PH_OPENED;
                end
                rps_pkg::PH_OPENED:
                begin
                    if (cur.step == rps_pkg::ST_ABORTED)
                        nxt.step = rps_pkg::ST_STANDBY;
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
        else
        begin
            case (cur.phase)
                rps_pkg::PH_OPENED:
                begin
                    nxt.phase = rps_pkg::PH_CLOSING;
                    // A fresh sequence runs its prepare step at once.
                    if (cur.step == rps_pkg::ST_STANDBY)
                    begin
                        nxt.drive.discharge = 1'b0;
                        nxt.drive.air_neg   = 1'b1;
                        nxt.step            = rps_pkg::ST_PRECHARGE;
                    end
                end
                rps_pkg::PH_CLOSING:
                begin
                    case (cur.step)
                        rps_pkg::ST_ABORTED:
                        begin
                            nxt.step = rps_pkg::ST_STANDBY;
                        end
                        rps_pkg::ST_STANDBY:
                        begin
                            nxt.step = rps_pkg::ST_STANDBY;
                        end
                        rps_pkg::ST_PREPARE:
                        begin
                            nxt.drive.discharge = 1'b0;
                            nxt.drive.air_neg   = 1'b1;
                            nxt.step            = rps_pkg::ST_PRECHARGE;
                        end
                        rps_pkg::ST_PRECHARGE:
                        begin
                            nxt.drive.precharge = 1'b1;
                            nxt.step            = rps_pkg::ST_WAIT;
                            nxt.time_reference  = item.time_ms;
                        end
                        rps_pkg::ST_WAIT:
                        begin
                            if (pre_done)
                            begin
                                nxt.step = rps_pkg::ST_AIRP;
                            end
                            else if (pre_timeout)
                            begin
                                // Timeout aborts, closing the discharge relay and opening the others.
                                nxt.step  = rps_pkg::ST_ABORTED;
                                nxt.drive = '{precharge: 1'b0, air_pos: 1'b0,
                                              air_neg: 1'b0, discharge: 1'b1};
                                nxt.phase = rps_pkg::PH_OPENED;
                                timed_out = 1'b1;
                            end
                        end
                        rps_pkg::ST_AIRP:
                        begin
                            nxt.drive.air_pos = 1'b1;
                            nxt.step          = rps_pkg::ST_FINISH;
                        end
                        rps_pkg::ST_FINISH:
                        begin
                            nxt.drive.precharge = 1'b0;
                            nxt.step            = rps_pkg::ST_STANDBY;
                            nxt.phase           = rps_pkg::PH_CLOSED;
                        end
                        default:
                        begin
                            nxt.drive = '{precharge: 1'b0, air_pos: 1'b0,
                                          air_neg: 1'b0, discharge: 1'b1};
                            nxt.phase = rps_pkg::PH_OPENED;
                            nxt.step  = rps_pkg::ST_STANDBY;
                        end
                    endcase
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule
